/* rtl/core/upe_pkg.sv */
// Package for the URL percent encoder: queue entry type, item kinds, phase type,
// constants and hex_digit. No dependencies; used by every module of the encoder.
`timescale 1ns / 1ps
`default_nettype none

package upe_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COUNT_W     = 9;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [BYTE_W-1:0] CHAR_PERCENT    = 8'h25;
  localparam logic [BYTE_W-1:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [BYTE_W-1:0] CHAR_SPACE      = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_NUL        = 8'h00;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_ESCAPE,
    KIND_TERM
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  typedef enum logic [1:0] {
    PHASE_IDLE,
    PHASE_HIGH,
    PHASE_LOW
  } phase_e;

  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
    logic [BYTE_W-1:0] r;
    if (nib < 4'd10) begin
      r = 8'h30 + {4'd0, nib};
    end else begin
      r = 8'h37 + {4'd0, nib};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/upe_front.sv */
// Front end of the URL percent encoder: accepts input items, classifies them
// and keeps the first-position flag and output count. Depends on upe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module upe_front #(
  parameter int unsigned OUT_LIMIT = 299
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [upe_pkg::BYTE_W-1:0]   in_byte_i,
  input  wire logic                         queue_full_i,
  output logic                              push_o,
  output upe_pkg::cmd_t                     push_cmd_o
);

  localparam logic [upe_pkg::COUNT_W-1:0] LIMIT = upe_pkg::COUNT_W'(OUT_LIMIT);

  logic                          at_start_q, at_start_d;
  logic [upe_pkg::COUNT_W-1:0]   count_q, count_d;
  logic                          accept;
  logic                          is_plain;
  logic [1:0]                    n_out;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;

  always_comb begin
    is_plain = ((in_byte_i >= 8'h61) && (in_byte_i <= 8'h7A)) ||
               ((in_byte_i >= 8'h41) && (in_byte_i <= 8'h5A)) ||
               ((in_byte_i >= 8'h30) && (in_byte_i <= 8'h39)) ||
               (in_byte_i == 8'h2D) || (in_byte_i == 8'h5F) ||
               (in_byte_i == 8'h2E) || (in_byte_i == 8'h2A);
  end

  always_comb begin
    at_start_d      = at_start_q;
    count_d         = count_q;
    push_o          = 1'b0;
    push_cmd_o.kind = upe_pkg::KIND_PLAIN;
    push_cmd_o.data = in_byte_i;
    n_out           = 2'd0;
    if (accept) begin
      if (in_byte_i == upe_pkg::CHAR_NUL) begin
        push_o          = 1'b1;
        push_cmd_o.kind = upe_pkg::KIND_TERM;
        at_start_d      = 1'b1;
        count_d         = '0;
      end else if (count_q < LIMIT) begin
        if (is_plain) begin
          push_o = 1'b1;
          n_out  = 2'd1;
        end else if (in_byte_i == upe_pkg::CHAR_SPACE) begin
          push_cmd_o.data = upe_pkg::CHAR_UNDERSCORE;
          if (!at_start_q) begin
            push_o = 1'b1;
            n_out  = 2'd1;
          end
        end else begin
          push_o          = 1'b1;
          push_cmd_o.kind = upe_pkg::KIND_ESCAPE;
          n_out           = 2'd3;
        end
        at_start_d = 1'b0;
        count_d    = count_q + {{(upe_pkg::COUNT_W-2){1'b0}}, n_out};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      count_q    <= '0;
    end else begin
      at_start_q <= at_start_d;
      count_q    <= count_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/upe_queue.sv */
// Short command queue between the front and back ends of the URL percent
// encoder. Depends on upe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module upe_queue (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  upe_pkg::cmd_t push_cmd_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         empty_o,
  output upe_pkg::cmd_t head_o
);

  localparam int unsigned PTR_W = $clog2(upe_pkg::QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(upe_pkg::QUEUE_DEPTH + 1);

  upe_pkg::cmd_t      entries_q [upe_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic               do_push, do_pop;

  assign full_o  = (fill_q == CNT_W'(upe_pkg::QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/upe_back.sv */
// Back end of the URL percent encoder: expands queued commands into output
// bytes held in an output register. Depends on upe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module upe_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        empty_i,
  input  upe_pkg::cmd_t                    head_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [upe_pkg::BYTE_W-1:0]       out_byte_o,
  output logic                             out_last_o
);

  upe_pkg::phase_e                 phase_q, phase_d;
  logic [upe_pkg::BYTE_W-1:0]      esc_q, esc_d;
  logic                            valid_q, valid_d;
  logic [upe_pkg::BYTE_W-1:0]      byte_q, byte_d;
  logic                            last_q, last_d;
  logic                            can_load;

  assign can_load    = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

  always_comb begin
    phase_d = phase_q;
    esc_d   = esc_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (can_load) begin
      case (phase_q)
        upe_pkg::PHASE_HIGH: begin
          valid_d = 1'b1;
          byte_d  = upe_pkg::hex_digit(esc_q[7:4]);
          last_d  = 1'b0;
          phase_d = upe_pkg::PHASE_LOW;
        end
        upe_pkg::PHASE_LOW: begin
          valid_d = 1'b1;
          byte_d  = upe_pkg::hex_digit(esc_q[3:0]);
          last_d  = 1'b0;
          phase_d = upe_pkg::PHASE_IDLE;
        end
        default: begin
          valid_d = !empty_i;
          if (!empty_i) begin
            pop_o = 1'b1;
            case (head_i.kind)
              upe_pkg::KIND_ESCAPE: begin
                byte_d  = upe_pkg::CHAR_PERCENT;
                last_d  = 1'b0;
                esc_d   = head_i.data;
                phase_d = upe_pkg::PHASE_HIGH;
              end
              upe_pkg::KIND_TERM: begin
                byte_d = upe_pkg::CHAR_NUL;
                last_d = 1'b1;
              end
              default: begin
                byte_d = head_i.data;
                last_d = 1'b0;
              end
            endcase
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    esc_q  <= esc_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= upe_pkg::PHASE_IDLE;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      valid_q <= valid_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/url_percent_encoder_top.sv */
// Top level of the URL percent encoder: front end, command queue, back end.
// Depends on upe_pkg, upe_front, upe_queue and upe_back.
//
//   Channel  | Dir | Payload                         | Item
//   s_axis   | in  | tdata[7:0] = in_byte            | one source byte
//   m_axis   | out | tdata[7:0] = out_byte, tlast    | one encoded byte
//
// A plain byte, a space after the first position or the terminator gives one output
// item, an escaped byte gives three, and a leading space or a byte past the output
// limit gives none. Sustained input is one item per cycle for plain text while the
// output is ready, slower for escaped text; the one-byte output register sets this. A
// four-entry queue lets input continue while the output is stalled. Reset sets the
// first-position flag and clears the count, the queue and the output valid flag.
`timescale 1ns / 1ps
`default_nettype none

module url_percent_encoder_top #(
  parameter int unsigned OUT_LIMIT = 299
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast
);

  logic          push, full, pop, empty;
  upe_pkg::cmd_t push_cmd, head;

  upe_front #(
    .OUT_LIMIT (OUT_LIMIT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .queue_full_i (full),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  upe_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  upe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* test/url_percent_encoder_top_test.sv */
// Self-checking bench for url_percent_encoder_top: directed table, limit test, random strings.
// Depends on upe_pkg and url_percent_encoder_top; checks output against predictor and table.
`timescale 1ns / 1ps
`default_nettype none

module url_percent_encoder_top_test;

  localparam int unsigned ENC_LIMIT = 299;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  typedef struct {
    logic [7:0]  src;
    bit          typed;
    int unsigned n;
    logic [7:0]  c0;
    logic [7:0]  c1;
    logic [7:0]  c2;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;

  enc_char_t   pending_chars [$];
  int unsigned mismatch_count = 0;
  bit          quiet = 1'b0;

  logic       at_first_pos = 1'b1;
  logic [8:0] enc_count = '0;

  string hex_chars = "0123456789ABCDEF";
  string plain_set = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-_.*";

  dir_row_t dir_tab [26] = '{
    '{upe_pkg::CHAR_NUL,   1'b1, 1, upe_pkg::CHAR_NUL, 8'h00, 8'h00},
    '{upe_pkg::CHAR_SPACE, 1'b1, 0, 8'h00, 8'h00, 8'h00},
    '{upe_pkg::CHAR_SPACE, 1'b1, 1, upe_pkg::CHAR_UNDERSCORE, 8'h00, 8'h00},
    '{"a", 1'b0, 0, 8'h00, 8'h00, 8'h00},
    '{"z", 1'b0, 0, 8'h00, 8'h00, 8'h00},
    '{"A", 1'b0, 0, 8'h00, 8'h00, 8'h00},
    '{"Z", 1'b0, 0, 8'h00, 8'h00, 8'h00},
    '{"0", 1'b0, 0, 8'h00, 8'h00, 8'h00},
    '{"9", 1'b0, 0, 8'h00, 8'h00, 8'h00},
    '{"-", 1'b0, 0, 8'h00, 8'h00, 8'h00},
    '{"_", 1'b0, 0, 8'h00, 8'h00, 8'h00},
    '{".", 1'b0, 0, 8'h00, 8'h00, 8'h00},
    '{"*", 1'b0, 0, 8'h00, 8'h00, 8'h00},
    '{8'hFF, 1'b1, 3, upe_pkg::CHAR_PERCENT, "F", "F"},
    '{8'h01, 1'b1, 3, upe_pkg::CHAR_PERCENT, "0", "1"},
    '{"/", 1'b0, 0, 8'h00, 8'h00, 8'h00},
    '{":", 1'b0, 0, 8'h00, 8'h00, 8'h00},
    '{"@", 1'b0, 0, 8'h00, 8'h00, 8'h00},
    '{"[", 1'b0, 0, 8'h00, 8'h00, 8'h00},
    '{8'h60, 1'b0, 0, 8'h00, 8'h00, 8'h00},
    '{"{", 1'b0, 0, 8'h00, 8'h00, 8'h00},
    '{8'h80, 1'b0, 0, 8'h00, 8'h00, 8'h00},
    '{upe_pkg::CHAR_NUL, 1'b1, 1, upe_pkg::CHAR_NUL, 8'h00, 8'h00},
    '{"x", 1'b0, 0, 8'h00, 8'h00, 8'h00},
    '{upe_pkg::CHAR_SPACE, 1'b0, 0, 8'h00, 8'h00, 8'h00},
    '{upe_pkg::CHAR_NUL, 1'b1, 1, upe_pkg::CHAR_NUL, 8'h00, 8'h00}
  };

  url_percent_encoder_top #(
    .OUT_LIMIT(ENC_LIMIT)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
  endtask

  function automatic int unsigned encode_char(input logic [7:0] src, output enc_char_t res [3]);
    int unsigned n;
    n = 0;
    for (int k = 0; k < 3; k++) begin
      res[k] = '{8'h00, 1'b0};
    end
    if (src == upe_pkg::CHAR_NUL) begin
      res[0] = '{upe_pkg::CHAR_NUL, 1'b1};
      at_first_pos = 1'b1;
      enc_count = '0;
      return 1;
    end
    if (enc_count >= ENC_LIMIT) begin
      return 0;
    end
    if ((src >= "a" && src <= "z") || (src >= "A" && src <= "Z") || (src >= "0" && src <= "9")
        || src == "-" || src == "_" || src == "." || src == "*") begin
      res[0] = '{src, 1'b0};
      n = 1;
    end else if (src == upe_pkg::CHAR_SPACE) begin
      if (!at_first_pos) begin
        res[0] = '{upe_pkg::CHAR_UNDERSCORE, 1'b0};
        n = 1;
      end
    end else begin
      res[0] = '{upe_pkg::CHAR_PERCENT, 1'b0};
      res[1] = '{hex_chars[src[7:4]], 1'b0};
      res[2] = '{hex_chars[src[3:0]], 1'b0};
      n = 3;
    end
    at_first_pos = 1'b0;
    enc_count = enc_count + 9'(n);
    return n;
  endfunction

  task automatic send_item(input dir_row_t row);
    enc_char_t   res [3];
    int unsigned n;
    while (!quiet && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= row.src;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n = encode_char(row.src, res);
    if (row.typed) begin
      n = row.n;
      res[0] = '{row.c0, row.src == upe_pkg::CHAR_NUL};
      res[1] = '{row.c1, 1'b0};
      res[2] = '{row.c2, 1'b0};
    end
    for (int k = 0; k < n; k++) begin
      pending_chars.push_back(res[k]);
    end
  endtask

  task automatic send_byte(input logic [7:0] src);
    dir_row_t row;
    row = '{src, 1'b0, 0, 8'h00, 8'h00, 8'h00};
    send_item(row);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : out_check
    enc_char_t want;
    m_axis_tready <= quiet || ($urandom_range(0, 99) >= 30);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected item out_byte=%h last=%b",
                                  m_axis_tdata, m_axis_tlast));
      end else begin
        want = pending_chars.pop_front();
        if (m_axis_tdata !== want.ch) begin
          report_mismatch($sformatf("out_byte %h, expected %h", m_axis_tdata, want.ch));
        end
        if (m_axis_tlast !== want.last) begin
          report_mismatch($sformatf("last %b, expected %b on out_byte %h",
                                    m_axis_tlast, want.last, want.ch));
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("** url_percent_encoder_top: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int unsigned rnd_items;
    int unsigned str_idx;
    int unsigned len;
    int unsigned esc_pct;
    int unsigned pick;
    logic [7:0]  c;
    bit          long_str;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i]);
    end

    // An escape begun just below the output limit is finished; later non-NUL bytes are dropped.
    for (int i = 0; i < 98; i++) begin
      send_byte(8'hA5);
    end
    send_byte("a");
    send_byte("b");
    send_byte("c");
    send_byte("d");
    send_byte(8'h7E);
    send_byte("e");
    send_byte(upe_pkg::CHAR_SPACE);
    send_byte(8'hC3);
    send_byte(upe_pkg::CHAR_NUL);
    wait_drained();

    rnd_items = 0;
    str_idx = 0;
    while (rnd_items < 230) begin
      long_str = (str_idx == 0) || ($urandom_range(0, 7) == 0);
      len = long_str ? $urandom_range(100, 170) : $urandom_range(0, 16);
      esc_pct = long_str ? 60 : 40;
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < esc_pct) begin
          c = 8'($urandom_range(1, 255));
        end else if (pick < esc_pct + 15) begin
          c = upe_pkg::CHAR_SPACE;
        end else begin
          c = plain_set[$urandom_range(0, plain_set.len() - 1)];
        end
        send_byte(c);
        rnd_items++;
        quiet = (rnd_items >= 100) && (rnd_items < 180);
      end
      send_byte(upe_pkg::CHAR_NUL);
      rnd_items++;
      if ($urandom_range(0, 4) == 0) begin
        wait_drained();
      end
      str_idx++;
    end

    quiet = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (pending_chars.size() != 0) begin
      report_mismatch($sformatf("%0d expected items never arrived", pending_chars.size()));
    end
    if (mismatch_count == 0) begin
      $display("** url_percent_encoder_top: PASSED **");
    end else begin
      $display("** url_percent_encoder_top: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
